### rtl/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

	localparam int CAPACITY = 64;
	localparam int ACT_W = 4;
	localparam int POS_W = 6;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int COUNT_W = 7;
	localparam int GROUP = 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_BACK  = 4'd0,
		ACT_PUSH_FRONT = 4'd1,
		ACT_POP_BACK   = 4'd2,
		ACT_POP_FRONT  = 4'd3,
		ACT_INSERT     = 4'd4,
		ACT_ERASE      = 4'd5,
		ACT_FIND       = 4'd6,
		ACT_MODIFY     = 4'd7,
		ACT_READ       = 4'd8,
		ACT_CLEAR      = 4'd9
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef struct packed {
		logic shift_up;
		logic shift_down;
		logic write;
		logic find;
		logic read;
	} cell_op_t;

endpackage

### rtl/sequence_list_engine.sv
`timescale 1ns / 1ps

// channel | handshake           | payload
// --------+---------------------+----------------------------------
// input   | in_valid / in_ready | action, position, value
// output  | out_valid/out_ready | status, found, read_value, count
//
// After acceptance the cell row updates and flags its entries, the groups of
// eight cells reduce, then the group outputs merge into the output register,
// which presents the result.
// Reset clears the length; element storage is not reset.
// A waiting result holds in the output register; the next request is taken
// once the previous one has left the reduction stages.

module sequence_list_engine #(
	parameter int CAPACITY = sle_pkg::CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sle_pkg::ACT_W-1:0]           action,
	input  logic [sle_pkg::POS_W-1:0]           position,
	input  logic signed [sle_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sle_pkg::STAT_W-1:0]          status,
	output logic                                found,
	output logic signed [sle_pkg::DATA_W-1:0]   read_value,
	output logic [sle_pkg::COUNT_W-1:0]         count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > sle_pkg::POS_W) ? CNT_W : sle_pkg::POS_W;
	localparam int NGRP = (CAPACITY + sle_pkg::GROUP - 1) / sle_pkg::GROUP;
	localparam int NPAD = NGRP * sle_pkg::GROUP;

	logic                        in_fire;
	logic                        out_load;
	logic [CNT_W-1:0]            len_q;
	logic [CNT_W-1:0]            len_d;
	logic [CNT_W-1:0]            ptr;
	sle_pkg::cell_op_t           op;
	sle_pkg::status_t            st_d;
	logic                        full;
	logic                        empty;
	logic                        pos_ok;

	logic                        v_s1;
	logic                        v_s2;
	sle_pkg::status_t            st_s1;
	sle_pkg::status_t            st_s2;

	logic                        out_valid_q;
	logic [sle_pkg::STAT_W-1:0]  status_q;
	logic                        found_q;
	logic [sle_pkg::DATA_W-1:0]  read_value_q;
	logic [sle_pkg::COUNT_W-1:0] count_q;

	logic [CAPACITY-1:0][sle_pkg::DATA_W-1:0] cell_data;
	logic [CAPACITY-1:0]                      cell_hit;
	logic [CAPACITY-1:0]                      cell_sel;
	logic [NPAD-1:0][sle_pkg::DATA_W-1:0]     pad_data;
	logic [NPAD-1:0]                          pad_hit;
	logic [NPAD-1:0]                          pad_sel;
	logic [NGRP-1:0]                          grp_hit;
	logic [NGRP-1:0][sle_pkg::DATA_W-1:0]     grp_pick;
	logic [sle_pkg::DATA_W-1:0]               merged;

	assign in_ready = !v_s1 && !v_s2;
	assign in_fire = in_valid && in_ready;
	assign out_load = v_s2 && (!out_valid_q || out_ready);

	assign full = (len_q == CNT_W'(CAPACITY));
	assign empty = (len_q == '0);
	assign pos_ok = (CMP_W'(position) < CMP_W'(len_q));

	always_comb begin
		op = '0;
		ptr = '0;
		st_d = sle_pkg::ST_OK;
		len_d = len_q;
		case (sle_pkg::action_t'(action))
			sle_pkg::ACT_PUSH_BACK: begin
				if (full) begin
					st_d = sle_pkg::ST_FULL;
				end else begin
					op.write = 1'b1;
					ptr = len_q;
					len_d = len_q + CNT_W'(1);
				end
			end
			sle_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					st_d = sle_pkg::ST_FULL;
				end else begin
					op.shift_up = 1'b1;
					len_d = len_q + CNT_W'(1);
				end
			end
			sle_pkg::ACT_POP_BACK: begin
				if (empty) begin
					st_d = sle_pkg::ST_EMPTY;
				end else begin
					len_d = len_q - CNT_W'(1);
				end
			end
			sle_pkg::ACT_POP_FRONT: begin
				if (empty) begin
					st_d = sle_pkg::ST_EMPTY;
				end else begin
					op.shift_down = 1'b1;
					len_d = len_q - CNT_W'(1);
				end
			end
			sle_pkg::ACT_INSERT: begin
				if (!pos_ok) begin
					st_d = sle_pkg::ST_BADPOS;
				end else if (full) begin
					st_d = sle_pkg::ST_FULL;
				end else begin
					op.shift_up = 1'b1;
					ptr = CNT_W'(position);
					len_d = len_q + CNT_W'(1);
				end
			end
			sle_pkg::ACT_ERASE: begin
				if (!pos_ok) begin
					st_d = sle_pkg::ST_BADPOS;
				end else begin
					op.shift_down = 1'b1;
					ptr = CNT_W'(position);
					len_d = len_q - CNT_W'(1);
				end
			end
			sle_pkg::ACT_FIND: begin
				op.find = 1'b1;
			end
			sle_pkg::ACT_MODIFY: begin
				if (!pos_ok) begin
					st_d = sle_pkg::ST_BADPOS;
				end else begin
					op.write = 1'b1;
					ptr = CNT_W'(position);
				end
			end
			sle_pkg::ACT_READ: begin
				if (!pos_ok) begin
					st_d = sle_pkg::ST_BADPOS;
				end else begin
					op.read = 1'b1;
					ptr = CNT_W'(position);
				end
			end
			sle_pkg::ACT_CLEAR: begin
				len_d = '0;
			end
			default: begin
				op = '0;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [sle_pkg::DATA_W-1:0] left_d;
		logic [sle_pkg::DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		sle_cell #(
			.CNT_W(CNT_W),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.load(in_fire),
			.op(op),
			.ptr(ptr),
			.len(len_q),
			.value(value),
			.left(left_d),
			.right(right_d),
			.data(cell_data[i]),
			.hit(cell_hit[i]),
			.sel(cell_sel[i])
		);
	end

	for (genvar i = 0; i < NPAD; i++) begin : g_pad
		if (i < CAPACITY) begin : g_real
			assign pad_data[i] = cell_data[i];
			assign pad_hit[i] = cell_hit[i];
			assign pad_sel[i] = cell_sel[i];
		end else begin : g_fill
			assign pad_data[i] = '0;
			assign pad_hit[i] = 1'b0;
			assign pad_sel[i] = 1'b0;
		end
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		sle_group u_group (
			.clk(clk),
			.arst_n(arst_n),
			.load(v_s1),
			.hit(pad_hit[g*sle_pkg::GROUP +: sle_pkg::GROUP]),
			.sel(pad_sel[g*sle_pkg::GROUP +: sle_pkg::GROUP]),
			.data(pad_data[g*sle_pkg::GROUP +: sle_pkg::GROUP]),
			.any_hit(grp_hit[g]),
			.pick(grp_pick[g])
		);
	end

	always_comb begin
		merged = '0;
		for (int g = 0; g < NGRP; g++) begin
			merged = merged | grp_pick[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			st_s1 <= sle_pkg::ST_OK;
			st_s2 <= sle_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			if (in_fire) begin
				len_q <= len_d;
				st_s1 <= st_d;
			end
			if (v_s1) begin
				v_s2 <= 1'b1;
				st_s2 <= st_s1;
			end else if (out_load) begin
				v_s2 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= st_s2;
			found_q <= |grp_hit;
			read_value_q <= merged;
			count_q <= sle_pkg::COUNT_W'(len_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found = found_q;
	assign read_value = read_value_q;
	assign count = count_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !v_s2)
		else $error("two requests in flight");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(CAPACITY))
		else $error("length beyond capacity");

	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_sel))
		else $error("more than one cell selected for read");

endmodule

### rtl/sle_cell.sv
`timescale 1ns / 1ps

module sle_cell #(
	parameter int CNT_W = 7,
	parameter int IDX = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  sle_pkg::cell_op_t               op,
	input  logic [CNT_W-1:0]                ptr,
	input  logic [CNT_W-1:0]                len,
	input  logic [sle_pkg::DATA_W-1:0]      value,
	input  logic [sle_pkg::DATA_W-1:0]      left,
	input  logic [sle_pkg::DATA_W-1:0]      right,
	output logic [sle_pkg::DATA_W-1:0]      data,
	output logic                            hit,
	output logic                            sel
);

	localparam logic [CNT_W-1:0] ME = CNT_W'(IDX);

	logic [sle_pkg::DATA_W-1:0] data_q;
	logic [sle_pkg::DATA_W-1:0] data_d;
	logic                       hit_q;
	logic                       sel_q;
	logic                       at_ptr;
	logic                       past_ptr;

	assign at_ptr = (ME == ptr);
	assign past_ptr = (ME > ptr);

	always_comb begin
		data_d = data_q;
		if (op.shift_up) begin
			if (past_ptr) begin
				data_d = left;
			end else if (at_ptr) begin
				data_d = value;
			end
		end else if (op.shift_down) begin
			if (past_ptr || at_ptr) begin
				data_d = right;
			end
		end else if (op.write && at_ptr) begin
			data_d = value;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (load) begin
			hit_q <= op.find && (ME < len) && (data_q == value);
			sel_q <= op.read && at_ptr;
		end
	end

	assign data = data_q;
	assign hit = hit_q;
	assign sel = sel_q;

endmodule

### rtl/sle_group.sv
`timescale 1ns / 1ps

module sle_group (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                load,
	input  logic [sle_pkg::GROUP-1:0]                           hit,
	input  logic [sle_pkg::GROUP-1:0]                           sel,
	input  logic [sle_pkg::GROUP-1:0][sle_pkg::DATA_W-1:0]      data,
	output logic                                                any_hit,
	output logic [sle_pkg::DATA_W-1:0]                          pick
);

	logic                         any_hit_q;
	logic [sle_pkg::DATA_W-1:0]   pick_q;
	logic [sle_pkg::DATA_W-1:0]   pick_d;

	always_comb begin
		pick_d = '0;
		for (int k = 0; k < sle_pkg::GROUP; k++) begin
			pick_d = pick_d | (sel[k] ? data[k] : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_hit_q <= 1'b0;
		end else if (load) begin
			any_hit_q <= |hit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pick_q <= pick_d;
		end
	end

	assign any_hit = any_hit_q;
	assign pick = pick_q;

endmodule
